// ===== rtl/lagged_fibonacci_junk_generator_assert.svh =====
// Assertion macros shared by the lagged Fibonacci junk generator RTL.
`ifndef LAGGED_FIBONACCI_JUNK_GENERATOR_ASSERT_SVH
`define LAGGED_FIBONACCI_JUNK_GENERATOR_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LFJG_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define LFJG_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define LFJG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfjg_pkg.sv =====
// Constants and codes shared by the lagged Fibonacci junk generator.
package lfjg_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned LAG_LONG      = 521;
  localparam int unsigned LAG_SHORT     = 32;
  localparam int unsigned SEED_WORDS    = 17;
  localparam int unsigned WARMUP_ROUNDS = 4;

  localparam int unsigned IDX_W   = $clog2(LAG_LONG);
  localparam int unsigned SC_W    = $clog2(SEED_WORDS + 1);
  localparam int unsigned RND_W   = $clog2(WARMUP_ROUNDS + 1);
  localparam int unsigned SKIP_W  = 2;
  localparam int unsigned COUNT_W = 3;

  localparam int unsigned EXP_SHL  = 23;
  localparam int unsigned EXP_SHR  = 9;
  localparam int unsigned EXP_FAR  = 17;
  localparam int unsigned EXP_NEAR = 16;

  localparam int unsigned LAST_POS    = LAG_LONG - 1;
  localparam int unsigned TAP_ADVANCE = LAG_LONG - LAG_SHORT;
  localparam int unsigned TAP_FAR     = LAG_LONG - EXP_FAR;
  localparam int unsigned TAP_NEAR    = LAG_LONG - EXP_NEAR;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

endpackage

// ===== rtl/lagged_fibonacci_junk_generator.sv =====
// Top level of the lagged Fibonacci junk generator: cell ring, sequencer and output.
//
//   channel | direction | handshake               | word contents
//   in      | input     | in_valid_i / in_ready_o  | op, seed_word, first_byte, byte_count
//   out     | output    | out_valid_o / out_ready_i| data_bytes, valid_bytes
//
// A load or fetch in stream order is accepted and finished in the cycle it is presented,
// so such words can follow back to back.
// Every 521st fetch is followed by a table advance through the whole ring.
// The 17th load is followed by an expansion pass over the rest of the ring and 4 full advances.
// An out-of-order load or fetch first rotates the ring one word per cycle to align.
// Reset clears the registers but not the table cells; the table holds nothing defined until seeded.
// A fetch that produces a word waits while the output register is still full.
`include "lagged_fibonacci_junk_generator_assert.svh"

module lagged_fibonacci_junk_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [lfjg_pkg::WORD_W-1:0]   seed_word_i,
  input  logic [lfjg_pkg::SKIP_W-1:0]   first_byte_i,
  input  logic [lfjg_pkg::COUNT_W-1:0]  byte_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfjg_pkg::WORD_W-1:0]   data_bytes_o,
  output logic [lfjg_pkg::COUNT_W-1:0]  valid_bytes_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEND,
    S_EXPAND,
    S_ADVANCE
  } state_e;

  state_e                         state_q;
  logic [lfjg_pkg::IDX_W-1:0]     head_q;
  logic [lfjg_pkg::IDX_W-1:0]     read_q;
  logic [lfjg_pkg::SC_W-1:0]      seed_cnt_q;
  logic [lfjg_pkg::RND_W-1:0]     rounds_q;
  logic                           op_q;
  logic [lfjg_pkg::WORD_W-1:0]    seed_q;
  logic [lfjg_pkg::SKIP_W-1:0]    skip_q;
  logic [lfjg_pkg::COUNT_W-1:0]   count_q;
  logic                           out_valid_q;
  logic [lfjg_pkg::WORD_W-1:0]    out_data_q;
  logic [lfjg_pkg::COUNT_W-1:0]   out_count_q;

  logic [lfjg_pkg::WORD_W-1:0]    cell_w [lfjg_pkg::LAG_LONG];
  logic [lfjg_pkg::WORD_W-1:0]    tail_d;
  logic                           shift_en;

  logic                           cur_op;
  logic [lfjg_pkg::WORD_W-1:0]    cur_seed;
  logic [lfjg_pkg::SKIP_W-1:0]    cur_skip;
  logic [lfjg_pkg::COUNT_W-1:0]   cur_count;
  logic [lfjg_pkg::SC_W-1:0]      load_slot;
  logic [lfjg_pkg::SC_W-1:0]      seed_cnt_d;
  logic [lfjg_pkg::IDX_W-1:0]     target;
  logic [lfjg_pkg::IDX_W-1:0]     head_d;
  logic                           head_last;
  logic                           act;
  logic                           aligned;
  logic                           out_free;
  logic                           do_load;
  logic                           do_fetch;
  logic [lfjg_pkg::COUNT_W-1:0]   emit_count;
  logic [lfjg_pkg::WORD_W-1:0]    emit_data;

  // Circular table: position 0 is the head, the last position takes the feedback word.
  for (genvar p = 0; p < lfjg_pkg::LAG_LONG; p++) begin : g_cell
    if (p == lfjg_pkg::LAST_POS) begin : g_tail
      lfjg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (tail_d),
        .word_o  (cell_w[p])
      );
    end else begin : g_body
      lfjg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (cell_w[p+1]),
        .word_o  (cell_w[p])
      );
    end
  end

  assign cur_op    = (state_q == S_IDLE) ? op_i         : op_q;
  assign cur_seed  = (state_q == S_IDLE) ? seed_word_i  : seed_q;
  assign cur_skip  = (state_q == S_IDLE) ? first_byte_i : skip_q;
  assign cur_count = (state_q == S_IDLE) ? byte_count_i : count_q;

  assign load_slot  = (seed_cnt_q >= lfjg_pkg::SC_W'(lfjg_pkg::SEED_WORDS)) ? '0 : seed_cnt_q;
  assign seed_cnt_d = load_slot + lfjg_pkg::SC_W'(1);
  assign target     = (cur_op == lfjg_pkg::OP_LOAD) ?
                      lfjg_pkg::IDX_W'(load_slot) : read_q;

  assign head_last = (head_q == lfjg_pkg::IDX_W'(lfjg_pkg::LAST_POS));
  assign head_d    = head_last ? '0 : head_q + lfjg_pkg::IDX_W'(1);

  assign in_ready_o = (state_q == S_IDLE);
  assign act        = (state_q == S_PEND) || (in_ready_o && in_valid_i);
  assign aligned    = (head_q == target);
  assign out_free   = !out_valid_q || out_ready_i;
  assign do_load    = act && aligned && (cur_op == lfjg_pkg::OP_LOAD);
  assign do_fetch   = act && aligned && (cur_op == lfjg_pkg::OP_FETCH) && out_free;

  assign shift_en = (act && !aligned) || do_load || do_fetch ||
                    (state_q == S_EXPAND) || (state_q == S_ADVANCE);

  always_comb begin
    case (state_q)
      S_EXPAND: begin
        tail_d = (cell_w[lfjg_pkg::TAP_FAR] << lfjg_pkg::EXP_SHL)
               ^ (cell_w[lfjg_pkg::TAP_NEAR] >> lfjg_pkg::EXP_SHR)
               ^ cell_w[lfjg_pkg::LAST_POS];
      end
      S_ADVANCE: begin
        tail_d = cell_w[0] ^ cell_w[lfjg_pkg::TAP_ADVANCE];
      end
      default: begin
        tail_d = do_load ? cur_seed : cell_w[0];
      end
    endcase
  end

  // The byte count is clipped to what is left after the dropped bytes.
  always_comb begin
    logic [lfjg_pkg::COUNT_W-1:0] avail;
    logic [lfjg_pkg::COUNT_W-1:0] rest;
    logic [lfjg_pkg::WORD_W-1:0]  mask;
    avail      = lfjg_pkg::COUNT_W'(4) - lfjg_pkg::COUNT_W'(cur_skip);
    emit_count = (cur_count > avail) ? avail : cur_count;
    rest       = lfjg_pkg::COUNT_W'(4) - emit_count;
    mask       = {lfjg_pkg::WORD_W{1'b1}} << {rest[1:0], 3'b000};
    emit_data  = (cell_w[0] << {cur_skip, 3'b000}) & mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      read_q      <= '0;
      seed_cnt_q  <= '0;
      rounds_q    <= '0;
      op_q        <= lfjg_pkg::OP_LOAD;
      seed_q      <= '0;
      skip_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_count_q <= '0;
    end else begin
      if (shift_en) begin
        head_q <= head_d;
      end
      if (do_fetch && (emit_count != '0)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_ready_o && in_valid_i) begin
        op_q    <= op_i;
        seed_q  <= seed_word_i;
        skip_q  <= first_byte_i;
        count_q <= byte_count_i;
      end
      case (state_q)
        S_IDLE, S_PEND: begin
          if (do_load) begin
            seed_cnt_q <= seed_cnt_d;
            if (seed_cnt_d == lfjg_pkg::SC_W'(lfjg_pkg::SEED_WORDS)) begin
              read_q  <= '0;
              state_q <= S_EXPAND;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (do_fetch) begin
            if (emit_count != '0) begin
              out_data_q  <= emit_data;
              out_count_q <= emit_count;
            end
            if (read_q == lfjg_pkg::IDX_W'(lfjg_pkg::LAST_POS)) begin
              read_q   <= '0;
              rounds_q <= lfjg_pkg::RND_W'(1);
              state_q  <= S_ADVANCE;
            end else begin
              read_q  <= read_q + lfjg_pkg::IDX_W'(1);
              state_q <= S_IDLE;
            end
          end else if (act) begin
            state_q <= S_PEND;
          end
        end
        S_EXPAND: begin
          if (head_last) begin
            rounds_q <= lfjg_pkg::RND_W'(lfjg_pkg::WARMUP_ROUNDS);
            state_q  <= S_ADVANCE;
          end
        end
        S_ADVANCE: begin
          if (head_last) begin
            if (rounds_q == lfjg_pkg::RND_W'(1)) begin
              state_q <= S_IDLE;
            end else begin
              rounds_q <= rounds_q - lfjg_pkg::RND_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_bytes_o  = out_data_q;
  assign valid_bytes_o = out_count_q;

  `LFJG_ASSERT_ALWAYS(a_head_range, head_q <= lfjg_pkg::IDX_W'(lfjg_pkg::LAST_POS),
                      "head index out of range")
  `LFJG_ASSERT_ALWAYS(a_seed_range, seed_cnt_q <= lfjg_pkg::SC_W'(lfjg_pkg::SEED_WORDS),
                      "seed count out of range")
  `LFJG_ASSERT_NEXT(a_sweep_steps, (state_q == S_EXPAND) || (state_q == S_ADVANCE),
                    head_q == $past(head_d), "ring did not step during a sweep")
  `LFJG_ASSERT_SAME(a_out_count, out_valid_q,
                    (out_count_q != '0) && (out_count_q <= lfjg_pkg::COUNT_W'(4)),
                    "output byte count out of range")
  `LFJG_ASSERT_SAME(a_expand_read, state_q == S_EXPAND, read_q == '0,
                    "read index not restarted during expansion")

endmodule

// ===== rtl/lfjg_cell.sv =====
// One word of the circular lag table, shifted toward the head on enable.
module lfjg_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [lfjg_pkg::WORD_W-1:0] word_i,
  output logic [lfjg_pkg::WORD_W-1:0] word_o
);

  logic [lfjg_pkg::WORD_W-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule
